[sv/lc3s_pkg.sv]
`default_nettype none
package lc3s_pkg;
  localparam int MemWordsDefault = 4096;
  localparam logic [15:0] WinBase = 16'h3000;

  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_EXEC   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [2:0] ST_RUN      = 3'd0;
  localparam logic [2:0] ST_TRAP     = 3'd1;
  localparam logic [2:0] ST_PC_OUT   = 3'd2;
  localparam logic [2:0] ST_RESERVED = 3'd3;
  localparam logic [2:0] ST_DATA_OUT = 3'd4;

  localparam logic [3:0] OP_BR  = 4'h0;
  localparam logic [3:0] OP_ADD = 4'h1;
  localparam logic [3:0] OP_LD  = 4'h2;
  localparam logic [3:0] OP_ST  = 4'h3;
  localparam logic [3:0] OP_JSR = 4'h4;
  localparam logic [3:0] OP_AND = 4'h5;
  localparam logic [3:0] OP_LDR = 4'h6;
  localparam logic [3:0] OP_STR = 4'h7;
  localparam logic [3:0] OP_RSV8 = 4'h8;
  localparam logic [3:0] OP_NOT = 4'h9;
  localparam logic [3:0] OP_LDI = 4'hA;
  localparam logic [3:0] OP_STI = 4'hB;
  localparam logic [3:0] OP_JMP = 4'hC;
  localparam logic [3:0] OP_RSV13 = 4'hD;
  localparam logic [3:0] OP_LEA = 4'hE;
  localparam logic [3:0] OP_TRAP = 4'hF;

  // memory address source
  typedef enum logic [1:0] {
    MA_OFFSET,
    MA_PC,
    MA_ADDR
  } maddr_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic       load_item;   // capture item fields
    logic       mem_we;      // write memory
    maddr_sel_t mem_sel;
    logic       load_ir;     // ir <= memory data, pc++
    logic       calc;        // compute addr / execute alu, write regs
    logic       load_ptr;    // addr <= memory data
    logic       load_data;   // write dr from memory data
    logic       load_rd;     // read_word <= memory data
    logic       clr_rd;
    logic       set_status;
    logic [2:0] status_code;
    logic       pc_check;    // final pc window check
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] func;
    logic       offset_ok;
    logic       halted;
    logic       pc_ok;
    logic       addr_ok;
    logic       mem_ok;      // memory data as address in window
    logic [3:0] opcode;
  } sts_t;
endpackage
`default_nettype wire

[sv/lc3_instruction_step_top.sv]
`default_nettype none
// Channel  | Handshake          | Fields
// ---------+--------------------+-----------------------------------------
// item in  | start & !busy      | func, mem_offset, write_word
// result   | done (one cycle)   | read_word, next_pc, cond_nzp, status
//
// States from accept to done: memory write, unused code and halted steps use
// idle, decode, finish; read adds S_READ; ALU/branch/jump/trap add S_FETCH,
// S_EXEC; then ST/STR add S_ADDR; LD/LDR S_ADDR, S_DATA; STI S_ADDR, S_PTR,
// S_IR; LDI all four. The single-port synchronous memory sets this order.
// rst is synchronous: pc 0x3000, registers, flags and status cleared;
// memory contents are undefined until written. Results cannot be stalled.
module lc3_instruction_step_top #(
  parameter int MEM_WORDS = lc3s_pkg::MemWordsDefault
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  output logic             busy,
  output logic             done,
  input  wire logic [1:0]  func,
  input  wire logic [11:0] mem_offset,
  input  wire logic [15:0] write_word,
  output logic [15:0]      read_word,
  output logic [15:0]      next_pc,
  output logic [2:0]       cond_nzp,
  output logic [2:0]       status
);
  lc3s_pkg::ctl_t ctl;
  lc3s_pkg::sts_t sts;

  lc3s_control u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .ctl(ctl),
    .busy(busy), .done(done)
  );

  lc3s_datapath #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk(clk), .rst(rst), .func(func), .mem_offset(mem_offset),
    .write_word(write_word), .ctl(ctl), .sts(sts), .read_word(read_word),
    .next_pc(next_pc), .cond_nzp(cond_nzp), .status(status)
  );

`ifndef SYNTHESIS
  // a nonzero status is sticky until reset
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(status) != lc3s_pkg::ST_RUN && !$past(rst) |-> status == $past(status))
    else $error("status changed while halted");
  // busy drops right after done
  a_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after done");
  a_cc: assert property (@(posedge clk) disable iff (rst)
    $countones(cond_nzp) <= 1) else $error("bad flags");
`endif
endmodule
`default_nettype wire

[sv/lc3s_datapath.sv]
`default_nettype none
module lc3s_datapath #(
  parameter int MEM_WORDS = lc3s_pkg::MemWordsDefault
) (
  input  wire              clk,
  input  wire              rst,
  input  wire logic [1:0]  func,
  input  wire logic [11:0] mem_offset,
  input  wire logic [15:0] write_word,
  input  lc3s_pkg::ctl_t   ctl,
  output lc3s_pkg::sts_t   sts,
  output logic [15:0]      read_word,
  output logic [15:0]      next_pc,
  output logic [2:0]       cond_nzp,
  output logic [2:0]       status
);
  localparam int AW = $clog2(MEM_WORDS);

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] mdata;
  logic [1:0]  func_q;
  logic [11:0] offset_q;
  logic [15:0] wword_q;
  logic [15:0] ir;
  logic [15:0] addr;
  logic [15:0] regs [8];
  logic [15:0] pc;
  logic [2:0]  nzp;
  logic [2:0]  stat;

  function automatic logic in_win(input logic [15:0] a);
    logic [16:0] hi;
    hi = {1'b0, lc3s_pkg::WinBase} + 17'(MEM_WORDS);
    return (a >= lc3s_pkg::WinBase) && ({1'b0, a} < hi);
  endfunction

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    return v[15] ? 3'b100 : ((v == 16'd0) ? 3'b010 : 3'b001);
  endfunction

  logic [2:0]  dr, sr1;
  logic [15:0] base, src2, sx5, sx6, sx9, sx11, pc_off9, base_off6, wdata;
  logic [AW-1:0] maddr;
  logic [15:0] pc_off_a;
  logic [15:0] addr_off;
  logic [15:0] pc_after;

  assign dr   = ir[11:9];
  assign sr1  = ir[8:6];
  assign base = regs[sr1];
  assign sx5  = {{11{ir[4]}}, ir[4:0]};
  assign sx6  = {{10{ir[5]}}, ir[5:0]};
  assign sx9  = {{7{ir[8]}}, ir[8:0]};
  assign sx11 = {{5{ir[10]}}, ir[10:0]};
  assign src2 = ir[5] ? sx5 : regs[ir[2:0]];
  assign pc_off9   = pc + sx9;
  assign base_off6 = base + sx6;
  assign pc_off_a  = pc - lc3s_pkg::WinBase;
  assign addr_off  = addr - lc3s_pkg::WinBase;

  always_comb begin
    case (ctl.mem_sel)
      lc3s_pkg::MA_OFFSET: maddr = AW'(offset_q);
      lc3s_pkg::MA_PC:     maddr = pc_off_a[AW-1:0];
      lc3s_pkg::MA_ADDR:   maddr = addr_off[AW-1:0];
      default:             maddr = AW'(offset_q);
    endcase
    wdata = (ctl.mem_sel == lc3s_pkg::MA_OFFSET) ? wword_q : regs[dr];
  end

  // pc after this cycle's execute step; the window check looks at it
  always_comb begin
    pc_after = pc;
    if (ctl.calc) begin
      case (ir[15:12])
        lc3s_pkg::OP_BR:  if ((dr & nzp) != 3'd0) pc_after = pc_off9;
        lc3s_pkg::OP_JMP: pc_after = base;
        lc3s_pkg::OP_JSR: pc_after = ir[11] ? 16'(pc + sx11) : base;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_we) begin
      mem[maddr] <= wdata;
    end
    mdata <= mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      func_q   <= func;
      offset_q <= mem_offset;
      wword_q  <= write_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= lc3s_pkg::WinBase;
      nzp  <= 3'd0;
      stat <= lc3s_pkg::ST_RUN;
      read_word <= 16'd0;
      for (int i = 0; i < 8; i++) begin
        regs[i] <= 16'd0;
      end
    end else begin
      if (ctl.clr_rd) begin
        read_word <= 16'd0;
      end
      if (ctl.load_rd) begin
        read_word <= mdata;
      end
      if (ctl.load_ir) begin
        ir <= mdata;
        pc <= pc + 16'd1;
      end
      if (ctl.load_ptr) begin
        addr <= mdata;
      end
      if (ctl.set_status) begin
        stat <= ctl.status_code;
      end
      if (ctl.pc_check && stat == lc3s_pkg::ST_RUN && !in_win(pc_after)) begin
        stat <= lc3s_pkg::ST_PC_OUT;
      end
      if (ctl.load_data) begin
        regs[dr] <= mdata;
        nzp      <= cc_of(mdata);
      end
      if (ctl.calc) begin
        case (ir[15:12])
          lc3s_pkg::OP_BR: pc <= pc_after;
          lc3s_pkg::OP_ADD: begin
            regs[dr] <= base + src2;
            nzp      <= cc_of(base + src2);
          end
          lc3s_pkg::OP_AND: begin
            regs[dr] <= base & src2;
            nzp      <= cc_of(base & src2);
          end
          lc3s_pkg::OP_NOT: begin
            regs[dr] <= ~base;
            nzp      <= cc_of(~base);
          end
          lc3s_pkg::OP_LEA: begin
            regs[dr] <= pc_off9;
            nzp      <= cc_of(pc_off9);
          end
          lc3s_pkg::OP_LD, lc3s_pkg::OP_LDI, lc3s_pkg::OP_ST,
          lc3s_pkg::OP_STI: addr <= pc_off9;
          lc3s_pkg::OP_LDR, lc3s_pkg::OP_STR: addr <= base_off6;
          lc3s_pkg::OP_JMP: pc <= pc_after;
          lc3s_pkg::OP_JSR: begin
            regs[7] <= pc;
            pc      <= pc_after;
          end
          default: ;
        endcase
      end
    end
  end

  assign sts.func      = func_q;
  assign sts.offset_ok = ({4'd0, offset_q} < 16'(MEM_WORDS));
  assign sts.halted    = (stat != lc3s_pkg::ST_RUN);
  assign sts.pc_ok     = in_win(pc);
  assign sts.addr_ok   = in_win(addr);
  assign sts.mem_ok    = in_win(mdata);
  assign sts.opcode    = ir[15:12];

  assign next_pc  = pc;
  assign cond_nzp = nzp;
  assign status   = stat;
endmodule
`default_nettype wire

[sv/lc3s_control.sv]
`default_nettype none
module lc3s_control (
  input  wire            clk,
  input  wire            rst,
  input  wire            start,
  input  lc3s_pkg::sts_t sts,
  output lc3s_pkg::ctl_t ctl,
  output logic           busy,
  output logic           done
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_READ, S_FETCH, S_IR, S_EXEC, S_ADDR, S_PTR,
    S_DATA, S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    ctl = '0;
    ctl.mem_sel = lc3s_pkg::MA_OFFSET;
    state_next = state;
    case (state)
      S_IDLE: begin
        ctl.load_item = start;
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = S_FINISH;
        ctl.clr_rd = 1'b1;
        case (sts.func)
          lc3s_pkg::FUNC_WRITE: ctl.mem_we = sts.offset_ok;
          lc3s_pkg::FUNC_READ:  if (sts.offset_ok) state_next = S_READ;
          lc3s_pkg::FUNC_EXEC: begin
            if (!sts.halted) begin
              if (sts.pc_ok) begin
                ctl.mem_sel = lc3s_pkg::MA_PC;
                state_next  = S_FETCH;
              end else begin
                ctl.set_status  = 1'b1;
                ctl.status_code = lc3s_pkg::ST_PC_OUT;
              end
            end
          end
          default: ;
        endcase
      end
      S_READ: begin
        ctl.load_rd = 1'b1;
        state_next  = S_FINISH;
      end
      S_FETCH: begin
        ctl.load_ir = 1'b1;
        state_next  = S_EXEC;
      end
      S_EXEC: begin
        ctl.calc   = 1'b1;
        state_next = S_FINISH;
        case (sts.opcode)
          lc3s_pkg::OP_TRAP: begin
            ctl.set_status  = 1'b1;
            ctl.status_code = lc3s_pkg::ST_TRAP;
          end
          lc3s_pkg::OP_RSV8, lc3s_pkg::OP_RSV13: begin
            ctl.set_status  = 1'b1;
            ctl.status_code = lc3s_pkg::ST_RESERVED;
          end
          lc3s_pkg::OP_LD, lc3s_pkg::OP_LDI, lc3s_pkg::OP_ST,
          lc3s_pkg::OP_STI, lc3s_pkg::OP_LDR, lc3s_pkg::OP_STR:
            state_next = S_ADDR;
          default: ctl.pc_check = 1'b1;
        endcase
      end
      S_ADDR: begin
        ctl.mem_sel = lc3s_pkg::MA_ADDR;
        if (!sts.addr_ok) begin
          ctl.set_status  = 1'b1;
          ctl.status_code = lc3s_pkg::ST_DATA_OUT;
          state_next      = S_FINISH;
        end else if (sts.opcode == lc3s_pkg::OP_ST ||
                     sts.opcode == lc3s_pkg::OP_STR) begin
          ctl.mem_we = 1'b1;
          ctl.pc_check = 1'b1;
          state_next = S_FINISH;
        end else if (sts.opcode == lc3s_pkg::OP_LDI ||
                     sts.opcode == lc3s_pkg::OP_STI) begin
          state_next = S_PTR;
        end else begin
          state_next = S_DATA;
        end
      end
      S_PTR: begin
        ctl.load_ptr = 1'b1;
        if (!sts.mem_ok) begin
          ctl.load_ptr    = 1'b0;
          ctl.set_status  = 1'b1;
          ctl.status_code = lc3s_pkg::ST_DATA_OUT;
          state_next      = S_FINISH;
        end else if (sts.opcode == lc3s_pkg::OP_STI) begin
          state_next = S_IR;
        end else begin
          state_next = S_IR;
        end
      end
      S_IR: begin
        // pointer now in addr
        ctl.mem_sel = lc3s_pkg::MA_ADDR;
        if (sts.opcode == lc3s_pkg::OP_STI) begin
          ctl.mem_we   = 1'b1;
          ctl.pc_check = 1'b1;
          state_next   = S_FINISH;
        end else begin
          state_next = S_DATA;
        end
      end
      S_DATA: begin
        ctl.load_data = 1'b1;
        ctl.pc_check  = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_FINISH);
endmodule
`default_nettype wire
